// File: sv/sfla_pkg.sv
package sfla_pkg;

   // Field widths of the request, response and register port.
   localparam int MODE_W      = 2;
   localparam int OFFSET_W    = 14;
   localparam int STATUS_W    = 2;
   localparam int SLOT_IDX_W  = 11;
   localparam int FREE_CNT_W  = 12;
   localparam int BYTES_W     = 15;
   localparam int ALIGN_W     = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_PAD_W   = RSP_DATA_W - STATUS_W - OFFSET_W - SLOT_IDX_W - FREE_CNT_W;

   localparam logic [BYTES_W-1:0] SIZE_CAP    = 15'd16384;
   localparam logic [BYTES_W-1:0] MIN_SLOT    = 15'd2;
   localparam logic [BYTES_W-1:0] RESET_BLOCK = 15'd16;
   localparam logic [ALIGN_W-1:0] ALIGN_CAP   = 4'd12;
   localparam int                 FREE_SAT    = 4095;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_FORMAT = 2'd2,
      MODE_NOP    = 2'd3
   } sfla_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } sfla_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OBJ_SIZE   = 1'b0,
      REG_ALIGN_LOG2 = 1'b1
   } sfla_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC_LOOK,
      ST_ALLOC_POP,
      ST_FREE_START,
      ST_FREE_WAIT,
      ST_FMT_GEOM,
      ST_FMT_DIV,
      ST_FMT_WAIT,
      ST_FMT_FILL,
      ST_RESULT
   } sfla_state_type;

   typedef struct packed {
      logic take;
      logic alloc_look;
      logic alloc_pop;
      logic div_free;
      logic free_commit;
      logic fmt_geom;
      logic div_fmt;
      logic fill_init;
      logic fill_step;
      logic fmt_commit;
      logic send;
   } sfla_cmd_type;

   typedef struct packed {
      sfla_mode_type req_mode;
      logic          slab_empty;
      logic          div_done;
      logic          fill_done;
      logic          out_free;
   } sfla_stat_type;

endpackage

// File: sv/sfla_divider.sv
module sfla_divider import sfla_pkg::*; #(
   parameter int DVD_W = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [BYTES_W-1:0] divisor,
   output logic               done,
   output logic [DVD_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BYTES_W-1:0] rem_ff, rem_in;
   logic [BYTES_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [BYTES_W:0]   trial;
   logic [BYTES_W:0]   diff;
   logic               fits;

   // One restoring step per cycle: the quotient register shifts the dividend out
   // at the top and takes quotient bits in at the bottom.
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/sfla_datapath.sv
module sfla_datapath import sfla_pkg::*; #(
   parameter int PAGE_BYTES = 4096,
   parameter int BIG_PAGES  = 4,
   parameter int CTL_BYTES  = 64,
   parameter int MAX_SLOTS  = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTES_W-1:0]     csr_wdata,
   input  sfla_cmd_type           cmd,
   output sfla_stat_type          stat
);

   localparam int REGION_BIG = BIG_PAGES * PAGE_BYTES;
   localparam int RGN_W      = $clog2(REGION_BIG + 1);
   localparam int DW         = (RGN_W > OFFSET_W) ? RGN_W : OFFSET_W;
   localparam int IDX_W      = $clog2(MAX_SLOTS);
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int FS_W       = (CNT_W > FREE_CNT_W) ? CNT_W : FREE_CNT_W;
   localparam int PROD_W     = CNT_W + BYTES_W;
   localparam int DVD_BIG    = (REGION_BIG > CTL_BYTES) ? REGION_BIG - CTL_BYTES : 0;
   localparam int DVD_SMALL  = (PAGE_BYTES > CTL_BYTES) ? PAGE_BYTES - CTL_BYTES : 0;
   localparam logic [BYTES_W+2:0] PAGE_LIMIT = (BYTES_W + 3)'(PAGE_BYTES);

   logic [BYTES_W-1:0]    blk_ff, blk_in;
   logic [ALIGN_W-1:0]    align_ff, align_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [BYTES_W-1:0]    slot_bytes_ff, slot_bytes_in;
   logic                  big_ff, big_in;
   logic [CNT_W-1:0]      head_ff, head_in;
   logic [FS_W-1:0]       fs_ff, fs_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      fill_cnt_ff, fill_cnt_in;
   logic [CNT_W-1:0]      fill_i_ff, fill_i_in;
   sfla_status_type       res_status_ff, res_status_in;
   logic [OFFSET_W-1:0]   res_boff_ff, res_boff_in;
   logic [SLOT_IDX_W-1:0] res_idx_ff, res_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]      rd_data_ff;

   logic [IDX_W-1:0]      link_mem [MAX_SLOTS];
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [IDX_W-1:0]      mem_wdata;

   logic [BYTES_W-1:0]    size_c, mask_c, round_c, slot_c;
   logic [ALIGN_W-1:0]    al_c;
   logic [BYTES_W+2:0]    size_x8;
   logic [CNT_W-1:0]      fill_next;
   logic [PROD_W-1:0]     prod_c;
   logic                  div_start;
   logic [DW-1:0]         div_dividend;
   logic                  div_done;
   logic [DW-1:0]         quo;
   logic                  free_ok;
   logic                  empty_c;

   // Geometry from the configuration registers, latched at format.
   always_comb begin
      size_c  = (blk_ff > SIZE_CAP) ? SIZE_CAP : blk_ff;
      al_c    = (align_ff > ALIGN_CAP) ? ALIGN_CAP : align_ff;
      mask_c  = (BYTES_W'(1) << al_c) - BYTES_W'(1);
      round_c = (size_c + mask_c) & ~mask_c;
      slot_c  = (round_c < MIN_SLOT) ? MIN_SLOT : round_c;
      size_x8 = {size_c, 3'b000};
   end

   assign div_start    = cmd.div_free | cmd.div_fmt;
   assign div_dividend = cmd.div_free ? DW'(offset_ff)
                       : (big_ff ? DW'(DVD_BIG) : DW'(DVD_SMALL));

   sfla_divider #(
      .DVD_W(DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (slot_bytes_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign fill_next = fill_i_ff + CNT_W'(1);
   assign prod_c    = PROD_W'(head_ff) * PROD_W'(slot_bytes_ff);
   assign free_ok   = quo < DW'(total_ff);
   assign empty_c   = (fs_ff == '0) || (head_ff >= total_ff);

   // The link memory has one write port, shared by the format sweep and free.
   assign mem_we    = cmd.fill_step | (cmd.free_commit & free_ok);
   assign mem_waddr = cmd.fill_step ? fill_i_ff[IDX_W-1:0] : quo[IDX_W-1:0];
   assign mem_wdata = cmd.fill_step ? fill_next[IDX_W-1:0] : IDX_W'(head_ff);

   always_comb begin
      blk_in        = blk_ff;
      align_in      = align_ff;
      offset_in     = offset_ff;
      slot_bytes_in = slot_bytes_ff;
      big_in        = big_ff;
      head_in       = head_ff;
      fs_in         = fs_ff;
      total_in      = total_ff;
      fill_cnt_in   = fill_cnt_ff;
      fill_i_in     = fill_i_ff;
      res_status_in = res_status_ff;
      res_boff_in   = res_boff_ff;
      res_idx_in    = res_idx_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      if (csr_we) begin
         unique case (sfla_reg_type'(csr_index))
            REG_OBJ_SIZE:   blk_in   = csr_wdata;
            REG_ALIGN_LOG2: align_in = csr_wdata[ALIGN_W-1:0];
         endcase
      end

      if (cmd.take) begin
         offset_in     = req_tdata[MODE_W +: OFFSET_W];
         res_status_in = STATUS_OK;
         res_boff_in   = '0;
         res_idx_in    = '0;
      end

      if (cmd.alloc_look) begin
         if (empty_c) begin
            res_status_in = STATUS_EMPTY;
         end else begin
            res_boff_in = OFFSET_W'(prod_c);
            res_idx_in  = SLOT_IDX_W'(head_ff);
         end
      end

      if (cmd.alloc_pop) begin
         head_in = CNT_W'(rd_data_ff);
         fs_in   = fs_ff - FS_W'(1);
      end

      if (cmd.free_commit) begin
         if (free_ok) begin
            head_in    = CNT_W'(quo);
            res_idx_in = SLOT_IDX_W'(quo);
            if (fs_ff < FS_W'(FREE_SAT)) begin
               fs_in = fs_ff + FS_W'(1);
            end
         end else begin
            res_status_in = STATUS_RANGE;
         end
      end

      if (cmd.fmt_geom) begin
         slot_bytes_in = slot_c;
         big_in        = size_x8 > PAGE_LIMIT;
      end

      if (cmd.fill_init) begin
         fill_cnt_in = (quo > DW'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(quo);
         fill_i_in   = '0;
      end

      if (cmd.fill_step) begin
         fill_i_in = fill_next;
      end

      if (cmd.fmt_commit) begin
         total_in = fill_cnt_ff;
         head_in  = '0;
         fs_in    = FS_W'(fill_cnt_ff);
      end

      if (cmd.send) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, FREE_CNT_W'(fs_ff), res_idx_ff, res_boff_ff,
                         res_status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff        <= RESET_BLOCK;
         align_ff      <= '0;
         slot_bytes_ff <= MIN_SLOT;
         big_ff        <= 1'b0;
         head_ff       <= '0;
         fs_ff         <= '0;
         total_ff      <= '0;
         fill_cnt_ff   <= '0;
         fill_i_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         blk_ff        <= blk_in;
         align_ff      <= align_in;
         slot_bytes_ff <= slot_bytes_in;
         big_ff        <= big_in;
         head_ff       <= head_in;
         fs_ff         <= fs_in;
         total_ff      <= total_in;
         fill_cnt_ff   <= fill_cnt_in;
         fill_i_ff     <= fill_i_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      offset_ff     <= offset_in;
      res_status_ff <= res_status_in;
      res_boff_ff   <= res_boff_in;
      res_idx_ff    <= res_idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
   end

   assign stat.req_mode   = sfla_mode_type'(req_tdata[MODE_W-1:0]);
   assign stat.slab_empty = empty_c;
   assign stat.div_done   = div_done;
   assign stat.fill_done  = fill_i_ff == fill_cnt_ff;
   assign stat.out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/sfla_ctrl.sv
module sfla_ctrl import sfla_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  sfla_stat_type stat,
   output sfla_cmd_type  cmd
);

   sfla_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (stat.req_mode)
                  MODE_ALLOC:  state_in = ST_ALLOC_LOOK;
                  MODE_FREE:   state_in = ST_FREE_START;
                  MODE_FORMAT: state_in = ST_FMT_GEOM;
                  MODE_NOP:    state_in = ST_RESULT;
               endcase
            end
         end
         ST_ALLOC_LOOK: state_in = stat.slab_empty ? ST_RESULT : ST_ALLOC_POP;
         ST_ALLOC_POP:  state_in = ST_RESULT;
         ST_FREE_START: state_in = ST_FREE_WAIT;
         ST_FREE_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_FMT_GEOM:   state_in = ST_FMT_DIV;
         ST_FMT_DIV:    state_in = ST_FMT_WAIT;
         ST_FMT_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_FMT_FILL;
            end
         end
         ST_FMT_FILL: begin
            if (stat.fill_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = state_ff == ST_IDLE;
      cmd             = '0;
      cmd.take        = (state_ff == ST_IDLE) & req_tvalid;
      cmd.alloc_look  = state_ff == ST_ALLOC_LOOK;
      cmd.alloc_pop   = state_ff == ST_ALLOC_POP;
      cmd.div_free    = state_ff == ST_FREE_START;
      cmd.free_commit = (state_ff == ST_FREE_WAIT) & stat.div_done;
      cmd.fmt_geom    = state_ff == ST_FMT_GEOM;
      cmd.div_fmt     = state_ff == ST_FMT_DIV;
      cmd.fill_init   = (state_ff == ST_FMT_WAIT) & stat.div_done;
      cmd.fill_step   = (state_ff == ST_FMT_FILL) & ~stat.fill_done;
      cmd.fmt_commit  = (state_ff == ST_FMT_FILL) & stat.fill_done;
      cmd.send        = (state_ff == ST_RESULT) & stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/slab_free_list_allocator_core.sv
// Slab allocator for one slab of equal-size slots kept on a singly linked free
// list in an on-chip link memory. A format request takes the object size and
// alignment registers, sets the slot size and slot count and rewrites the list so
// that every slot links to the next; alloc pops the head slot and returns its byte
// offset, free turns a byte offset into a slot and pushes it. One request is
// worked at a time, and the next one is taken while a response still waits in the
// output register. Alloc takes the next head from the registered link memory
// read. Free divides the offset by the slot size in the radix-2 divider, which
// produces one quotient bit per cycle over DW, the dividend width (15 at the
// default parameters). Format divides the slab area by the slot size in the same
// divider, then the link sweep writes one memory entry per cycle; the unused mode
// goes straight to the response. There is no clearing pass after reset: until the
// first format the slab has no slots, alloc answers empty and free answers out of
// range. Double frees are not detected.
module slab_free_list_allocator_core import sfla_pkg::*; #(
   parameter int PAGE_BYTES = 4096,
   parameter int BIG_PAGES  = 4,
   parameter int CTL_BYTES  = 64,
   parameter int MAX_SLOTS  = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] mode, [15:2] offset
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status, [15:2] block_offset, [26:16] slot_index, [38:27] free_count,
   // [39] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTES_W-1:0]     csr_wdata
);

   sfla_cmd_type  cmd;
   sfla_stat_type stat;

   sfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfla_datapath #(
      .PAGE_BYTES (PAGE_BYTES),
      .BIG_PAGES  (BIG_PAGES),
      .CTL_BYTES  (CTL_BYTES),
      .MAX_SLOTS  (MAX_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// File: sv/sfla_checker.sv
module sfla_checker import sfla_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Requests are worked one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is at work");

   // A fresh response appears only as the controller returns to idle.
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("response raised while a request is still at work");

   // A failed request reports no block and no slot.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_OK |-> rsp_tdata[26:2] == '0)
      else $error("failed request carries a block offset or slot index");

endmodule

bind slab_free_list_allocator_core sfla_checker u_sfla_checker (.*);
